/* rtl/sha256_pkg.sv */
// shared beat types for the sha-256 stream hasher
package sha256_pkg;

  // one input beat: message bytes, big-endian, first byte in bits 31:24
  typedef struct packed {
    logic [31:0] message_word;
    logic [2:0]  valid_bytes;
    logic        final_word;
  } msg_item_t;

  // one result beat: a word of the finished digest
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_done;
  } digest_item_t;

  // one packed block word between front and back, last marks the closing word of a message
  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } blk_word_t;

endpackage

/* rtl/sha256_stream_hasher.sv */
// top level of the sha-256 stream hasher
// usage:
//   input channel: push / full, one beat is a big-endian message word with its
//   byte count (0..4, larger counts act as 4) and a final flag; a short word
//   continues at the next byte position, a final word with no bytes closes
//   the message with padding only
//   result channel: empty / pop, eight digest beats per message, index 0
//   first, digest_done on index 7; a beat stays on digest_o until popped
// throughput:
//   the packer takes one byte a cycle while the block word queue has room;
//   each 64-byte block costs the compression engine 16 queue pops, 64 rounds
//   and a chaining add, and the engine pops no word of the next block until
//   that add is done and, after a closing block, its digest is popped
// closing a message:
//   after the final beat the packer adds padding and the bit length (up to
//   two blocks); the engine pops the last block word, runs the rounds and
//   the chaining add, and then shows the digest
// reset: chaining value goes to the initial hash, counters and queue clear
// stall: while the result side is not popped the engine holds; the block
// word queue keeps filling and push is held off by full once it is full
module sha256_stream_hasher #(
  parameter int unsigned FifoDepth = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  input  sha256_pkg::msg_item_t     message_i,
  output logic                      full,
  output logic                      empty,
  input  logic                      pop,
  output sha256_pkg::digest_item_t  digest_o
);
  import sha256_pkg::*;

  // packed block words from the front to the engine
  blk_word_t blk_wdata;
  blk_word_t blk_rdata;
  logic      blk_push;
  logic      blk_full;
  logic      blk_pop;
  logic      blk_empty;

  // front: byte packing, length count and padding
  sha256_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .message_i  (message_i),
    .full       (full),
    .blk_push_o (blk_push),
    .blk_word_o (blk_wdata),
    .blk_full_i (blk_full)
  );

  // decoupling queue, one block deep by default
  sha256_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (blk_push),
    .wdata_i (blk_wdata),
    .full_o  (blk_full),
    .pop_i   (blk_pop),
    .rdata_o (blk_rdata),
    .empty_o (blk_empty)
  );

  // back: compression rounds and digest beats
  sha256_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .blk_empty_i (blk_empty),
    .blk_word_i  (blk_rdata),
    .blk_pop_o   (blk_pop),
    .empty       (empty),
    .digest_o    (digest_o),
    .pop         (pop)
  );

`ifndef SYNTHESIS
  // the packer never closes a word into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_push |-> !blk_full)
    else $error("block word pushed into full queue");

  // a digest always starts at index 0
  a_first_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(empty) |-> (digest_o.digest_index == 3'd0))
    else $error("digest did not start at index 0");

  // after the closing beat is taken the result side goes empty
  a_done_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && digest_o.digest_done) |=> empty)
    else $error("result side not empty after last digest beat");
`endif

endmodule

/* rtl/sha256_front.sv */
// byte packer and padding sequencer, produces 32-bit block words
module sha256_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  input  sha256_pkg::msg_item_t  message_i,
  output logic                   full,
  output logic                   blk_push_o,
  output sha256_pkg::blk_word_t  blk_word_o,
  input  logic                   blk_full_i
);
  import sha256_pkg::*;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenOffset = 6'd56;
  localparam logic [5:0] LenLast = LenOffset - 6'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DATA,
    S_PAD,
    S_ZERO,
    S_LEN
  } state_e;

  state_e      state_q;
  logic [2:0]  cnt_q;
  logic        last_q;
  logic [63:0] total_q;
  logic [63:0] total_d;
  logic [5:0]  fill_q;
  logic [2:0]  lcnt_q;
  logic [31:0] word_q;
  logic [63:0] len_q;
  logic [23:0] acc_q;

  logic        byte_en;
  logic [7:0]  byte_val;
  logic        stall;
  logic        step;
  logic        accept;
  logic        enter_pad;
  logic        len_done;
  logic [2:0]  in_cnt;

  always_comb begin
    byte_en  = 1'b0;
    byte_val = 8'h00;
    case (state_q)
      S_DATA: begin
        byte_en  = 1'b1;
        byte_val = word_q[31:24];
      end
      S_PAD: begin
        byte_en  = 1'b1;
        byte_val = PadByte;
      end
      S_ZERO: begin
        byte_en  = 1'b1;
        byte_val = 8'h00;
      end
      S_LEN: begin
        byte_en  = 1'b1;
        byte_val = len_q[63:56];
      end
      default: begin
        byte_en  = 1'b0;
        byte_val = 8'h00;
      end
    endcase
  end

  // a byte that closes a word needs room in the queue
  assign stall = byte_en && (fill_q[1:0] == 2'd3) && blk_full_i;
  assign step  = byte_en && !stall;

  // take the next beat while the last data byte of a plain word goes out
  assign full = !((state_q == S_IDLE) ||
                  ((state_q == S_DATA) && (cnt_q == 3'd1) && !last_q && step));
  assign accept = push && !full;
  assign in_cnt = (message_i.valid_bytes > 3'd4) ? 3'd4 : message_i.valid_bytes;

  assign len_done = (state_q == S_LEN) && step && (lcnt_q == 3'd7);
  assign total_d  = len_done ? 64'd0
                  : total_q + {63'd0, (state_q == S_DATA) && step};
  assign enter_pad = ((state_q == S_DATA) && step && (cnt_q == 3'd1) && last_q) ||
                     (accept && (in_cnt == 3'd0) && message_i.final_word);

  assign blk_push_o      = step && (fill_q[1:0] == 2'd3);
  assign blk_word_o.word = {acc_q, byte_val};
  assign blk_word_o.last = (state_q == S_LEN) && (lcnt_q == 3'd7);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= 3'd0;
      last_q  <= 1'b0;
      total_q <= 64'd0;
      fill_q  <= 6'd0;
      lcnt_q  <= 3'd0;
    end else begin
      total_q <= total_d;
      if (step) begin
        fill_q <= fill_q + 6'd1;
      end
      case (state_q)
        S_IDLE: begin
        end
        S_DATA: begin
          if (step) begin
            cnt_q <= cnt_q - 3'd1;
            if (cnt_q == 3'd1) begin
              state_q <= last_q ? S_PAD : S_IDLE;
            end
          end
        end
        S_PAD: begin
          if (step) begin
            lcnt_q  <= 3'd0;
            state_q <= (fill_q == LenLast) ? S_LEN : S_ZERO;
          end
        end
        S_ZERO: begin
          if (step && (fill_q == LenLast)) begin
            lcnt_q  <= 3'd0;
            state_q <= S_LEN;
          end
        end
        S_LEN: begin
          if (step) begin
            lcnt_q <= lcnt_q + 3'd1;
            if (lcnt_q == 3'd7) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      if (accept) begin
        cnt_q  <= in_cnt;
        last_q <= message_i.final_word;
        if (in_cnt == 3'd0) begin
          state_q <= message_i.final_word ? S_PAD : S_IDLE;
        end else begin
          state_q <= S_DATA;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      acc_q <= {acc_q[15:0], byte_val};
    end
    if (accept) begin
      word_q <= message_i.message_word;
    end else if ((state_q == S_DATA) && step) begin
      word_q <= {word_q[23:0], 8'h00};
    end
    if (enter_pad) begin
      len_q <= {total_d[60:0], 3'b000};
    end else if ((state_q == S_LEN) && step) begin
      len_q <= {len_q[55:0], 8'h00};
    end
  end

endmodule

/* rtl/sha256_fifo.sv */
// block word queue between the packer and the compression engine
module sha256_fifo #(
  parameter int unsigned Depth = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  sha256_pkg::blk_word_t  wdata_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output sha256_pkg::blk_word_t  rdata_o,
  output logic                   empty_o
);
  import sha256_pkg::*;

  localparam int unsigned AW = $clog2(Depth);
  localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);
  localparam logic [AW:0] FullCnt = (AW + 1)'(Depth);

  blk_word_t     mem_q [Depth];
  logic [AW-1:0] wr_q;
  logic [AW-1:0] rd_q;
  logic [AW:0]   cnt_q;
  logic          do_push;
  logic          do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastIdx) ? '0 : wr_q + AW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastIdx) ? '0 : rd_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (AW + 1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (AW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

/* rtl/sha256_core.sv */
// sha-256 compression engine, one round per cycle, and digest output
module sha256_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      blk_empty_i,
  input  sha256_pkg::blk_word_t     blk_word_i,
  output logic                      blk_pop_o,
  output logic                      empty,
  output sha256_pkg::digest_item_t  digest_o,
  input  logic                      pop
);
  import sha256_pkg::*;

  localparam logic [31:0] Iv [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [1:0] {
    B_LOAD,
    B_ROUND,
    B_ADD,
    B_OUT
  } state_e;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  state_e      state_q;
  logic [3:0]  load_q;
  logic [5:0]  rnd_q;
  logic        last_q;
  logic [2:0]  idx_q;
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];

  logic [31:0] sum1;
  logic [31:0] sum0;
  logic [31:0] choose;
  logic [31:0] major;
  logic [31:0] sig1;
  logic [31:0] sig0;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] w_new;
  logic        load_done;

  assign sum1   = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
  assign sum0   = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
  assign choose = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign major  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1     = v_q[7] + sum1 + choose + RoundK[rnd_q] + w_q[0];
  assign t2     = sum0 + major;

  // window holds w[r..r+15], next entry is w[r+16]
  assign sig1  = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
  assign sig0  = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
  assign w_new = sig1 + w_q[9] + sig0 + w_q[0];

  assign blk_pop_o = (state_q == B_LOAD) && !blk_empty_i;
  assign load_done = blk_pop_o && (load_q == 4'd15);

  assign empty                 = (state_q != B_OUT);
  assign digest_o.digest_word  = h_q[idx_q];
  assign digest_o.digest_index = idx_q;
  assign digest_o.digest_done  = (idx_q == 3'd7);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_LOAD;
      load_q  <= 4'd0;
      rnd_q   <= 6'd0;
      last_q  <= 1'b0;
      idx_q   <= 3'd0;
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= Iv[i];
      end
    end else begin
      case (state_q)
        B_LOAD: begin
          if (blk_pop_o) begin
            load_q <= load_q + 4'd1;
            if (load_q == 4'd15) begin
              rnd_q   <= 6'd0;
              last_q  <= blk_word_i.last;
              state_q <= B_ROUND;
            end
          end
        end
        B_ROUND: begin
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) begin
            state_q <= B_ADD;
          end
        end
        B_ADD: begin
          for (int i = 0; i < 8; i++) begin
            h_q[i] <= h_q[i] + v_q[i];
          end
          idx_q   <= 3'd0;
          state_q <= last_q ? B_OUT : B_LOAD;
        end
        B_OUT: begin
          if (pop) begin
            idx_q <= idx_q + 3'd1;
            if (idx_q == 3'd7) begin
              for (int i = 0; i < 8; i++) begin
                h_q[i] <= Iv[i];
              end
              state_q <= B_LOAD;
            end
          end
        end
        default: begin
          state_q <= B_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (blk_pop_o) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i + 1];
      end
      w_q[15] <= blk_word_i.word;
    end else if (state_q == B_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i + 1];
      end
      w_q[15] <= w_new;
    end
    if (load_done) begin
      for (int i = 0; i < 8; i++) begin
        v_q[i] <= h_q[i];
      end
    end else if (state_q == B_ROUND) begin
      for (int i = 1; i < 8; i++) begin
        v_q[i] <= v_q[i - 1];
      end
      v_q[4] <= v_q[3] + t1;
      v_q[0] <= t1 + t2;
    end
  end

endmodule
